// ===== sv/peak_vote_index_selector_top_defines.svh =====
// Assertion macros for the top file, which checks its own logic.
`ifndef PEAK_VOTE_INDEX_SELECTOR_TOP_DEFINES_SVH
`define PEAK_VOTE_INDEX_SELECTOR_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PVIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PVIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/pvis_pkg.sv =====
package pvis_pkg;

  // Sequence capacity and field widths.
  localparam int MAX_POINTS = 256;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int SCORE_W    = 16;
  localparam int SPR_W      = SCORE_W + 1;
  localparam int POS_W      = 9;
  localparam int VOTE_W     = 2;
  localparam int STAT_W     = 2;

  // Depth of the queue between the front and the back.
  localparam int Q_DEPTH    = 2;
  localparam int QP_W       = $clog2(Q_DEPTH);
  localparam int QC_W       = $clog2(Q_DEPTH + 1);

  // Status codes of a result word.
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SHORT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVF   = 2'd2;

  // One position offered to the vote judge.
  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [VOTE_W-1:0] votes;
    logic [SPR_W-1:0]  spread;
  } cand_t;

  // One word from the front to the back.
  typedef struct packed {
    logic  a_valid;
    cand_t a;
    logic  last;
    logic  short_seq;
    logic  ovf;
    cand_t b;
    cand_t c;
  } entry_t;

  localparam cand_t BEST_INIT = '{pos: POS_W'(1), votes: '0, spread: '0};

  // A candidate replaces the best one on more votes, or on equal votes and a larger spread.
  function automatic cand_t judge(cand_t best, cand_t cand);
    cand_t result;
    result = best;
    if (cand.votes > best.votes) begin
      result = cand;
    end else if (cand.votes == best.votes && cand.spread > best.spread) begin
      result = cand;
    end
    return result;
  endfunction

endpackage

// ===== sv/pvis_front.sv =====
module pvis_front
  import pvis_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [SCORE_W-1:0]   score,
  input  logic                 is_last,
  output logic                 q_push,
  output entry_t               q_data
);

  logic [SCORE_W-1:0] rs [3];
  logic [VOTE_W-1:0]  pv [3];
  logic [SPR_W-1:0]   ps [2];
  logic [CNT_W-1:0]   count;
  logic               overflow_seen;

  logic [SCORE_W-1:0] rs_next [3];
  logic [VOTE_W-1:0]  pv_next [3];
  logic [SPR_W-1:0]   ps_next [2];
  logic [CNT_W-1:0]   count_next;

  logic               take;
  logic               win;
  logic [CNT_W-1:0]   n;
  logic [SCORE_W-1:0] dab, dbc, dac;
  logic [SPR_W-1:0]   d1, d2, d3;
  logic [VOTE_W-1:0]  pv_new [3];
  logic [SPR_W-1:0]   first_spread;

  // Window update and vote classification for one word.
  always_comb begin
    take = count < CNT_W'(MAX_POINTS);
    n    = count + CNT_W'(1);
    win  = n >= CNT_W'(3);

    dab = (rs[2] > rs[1]) ? rs[2] - rs[1] : rs[1] - rs[2];
    dbc = (rs[2] > score) ? rs[2] - score : score - rs[2];
    dac = (rs[1] > score) ? rs[1] - score : score - rs[1];
    d1  = {1'b0, dab} + {1'b0, dac};
    d2  = {1'b0, dab} + {1'b0, dbc};
    d3  = {1'b0, dbc} + {1'b0, dac};

    // Window members are rs[1], rs[2] and the new score.
    pv_new[0] = pv[1];
    pv_new[1] = pv[2];
    pv_new[2] = '0;
    if (rs[1] > rs[2] && rs[1] > score && d1 > d2 && d1 > d3) begin
      pv_new[0] = pv[1] + VOTE_W'(1);
    end
    if (rs[2] > rs[1] && rs[2] > score && d2 > d1 && d2 > d3) begin
      pv_new[1] = pv[2] + VOTE_W'(1);
    end
    if (score > rs[2] && score > rs[1] && d3 > d1 && d3 > d2) begin
      pv_new[2] = VOTE_W'(1);
    end
    first_spread = (n == CNT_W'(3)) ? d1 : ps[0];

    rs_next    = rs;
    pv_next    = pv;
    ps_next    = ps;
    count_next = count;
    if (take) begin
      rs_next    = '{rs[1], rs[2], score};
      count_next = n;
      if (win) begin
        pv_next = pv_new;
        ps_next = '{d2, d3};
      end else begin
        pv_next = '{pv[1], pv[2], '0};
      end
    end

    // Position n-2 is final once its last window has been seen.
    q_data.a_valid   = take && win;
    q_data.a.pos     = POS_W'(n - CNT_W'(2));
    q_data.a.votes   = pv_new[0];
    q_data.a.spread  = first_spread;
    q_data.last      = is_last;
    q_data.short_seq = count_next < CNT_W'(3);
    q_data.ovf       = overflow_seen || !take;
    q_data.b.pos     = POS_W'(count_next - CNT_W'(1));
    q_data.b.votes   = pv_next[1];
    q_data.b.spread  = ps_next[0];
    q_data.c.pos     = POS_W'(count_next);
    q_data.c.votes   = pv_next[2];
    q_data.c.spread  = ps_next[1];

    q_push = in_valid && (q_data.a_valid || is_last);
  end

  // Sequence state; the last word returns it to the start of a new sequence.
  always_ff @(posedge clk) begin
    if (rst || (in_valid && is_last)) begin
      rs            <= '{default: '0};
      pv            <= '{default: '0};
      ps            <= '{default: '0};
      count         <= '0;
      overflow_seen <= 1'b0;
    end else if (in_valid) begin
      rs    <= rs_next;
      pv    <= pv_next;
      ps    <= ps_next;
      count <= count_next;
      if (!take) begin
        overflow_seen <= 1'b1;
      end
    end
  end

endmodule

// ===== sv/pvis_queue.sv =====
module pvis_queue
  import pvis_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wr_data,
  output logic   full,
  input  logic   pop,
  output entry_t rd_data,
  output logic   empty
);

  entry_t            slots [Q_DEPTH];
  logic [QP_W-1:0]   wr_ptr;
  logic [QP_W-1:0]   rd_ptr;
  logic [QC_W-1:0]   fill;

  assign full    = fill == QC_W'(Q_DEPTH);
  assign empty   = fill == '0;
  assign rd_data = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + QP_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + QP_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QC_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QC_W'(1);
      end
    end
  end

endmodule

// ===== sv/pvis_back.sv =====
module pvis_back
  import pvis_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  entry_t              q_data,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output logic [POS_W-1:0]    chosen_position,
  output logic [STAT_W-1:0]   status
);

  cand_t best;
  cand_t best_a;
  cand_t best_c;
  logic  out_valid;

  // Judge the finished position, then the two tail positions on the last word.
  always_comb begin
    best_a = q_data.a_valid ? judge(best, q_data.a) : best;
    best_c = judge(judge(best_a, q_data.b), q_data.c);
    q_pop  = !q_empty && (!q_data.last || !out_valid || pop);
  end

  assign empty = !out_valid;

  // Running best position.
  always_ff @(posedge clk) begin
    if (rst) begin
      best <= BEST_INIT;
    end else if (q_pop) begin
      best <= q_data.last ? BEST_INIT : best_a;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid && !pop) || (q_pop && q_data.last);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.last) begin
      if (q_data.short_seq) begin
        chosen_position <= POS_W'(1);
        status          <= STAT_SHORT;
      end else begin
        chosen_position <= best_c.pos;
        status          <= q_data.ovf ? STAT_OVF : STAT_OK;
      end
    end
  end

endmodule

// ===== sv/peak_vote_index_selector_top.sv =====
// Channel   Handshake            Word
// input     push / full          score[15:0], is_last
// result    pop / empty          chosen_position[8:0], status[1:0]
//
// One score is taken every cycle while full is low; the front updates the three-score
// window in the cycle it accepts a word and writes at most one word into a two-entry queue.
// The back judges one queued word per cycle unless stalled and holds one result in its
// output register; a result reaches it via the queue after its last score is accepted.
// Reset is synchronous and empties the queue, the window and the result register.
// Only the final word of a sequence waits on a held result; full rises when the queue fills.
`include "peak_vote_index_selector_top_defines.svh"

module peak_vote_index_selector_top
  import pvis_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [SCORE_W-1:0]  score,
  input  logic                is_last,
  output logic                empty,
  input  logic                pop,
  output logic [POS_W-1:0]    chosen_position,
  output logic [STAT_W-1:0]   status
);

  logic   accept;
  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_empty;
  entry_t q_wr;
  entry_t q_rd;

  assign accept = push && !q_full;
  assign full   = q_full;

  // Front: window, spreads and votes.
  pvis_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .score    (score),
    .is_last  (is_last),
    .q_push   (q_push),
    .q_data   (q_wr)
  );

  // Queue between front and back.
  pvis_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  // Back: vote judge and result register.
  pvis_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_data          (q_rd),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .chosen_position (chosen_position),
    .status          (status)
  );

  // The back only stalls on a final word while an unread result sits in the output.
  `PVIS_ASSERT_NOW(a_back_stall, !q_empty && !q_pop, q_rd.last && !empty && !pop, "back stalled without cause")
  // A short sequence always reports the first position.
  `PVIS_ASSERT_NOW(a_short_pos, !empty && status == STAT_SHORT, chosen_position == POS_W'(1), "short result position")
  // A result position lies within the capacity.
  `PVIS_ASSERT_NOW(a_pos_range, !empty, chosen_position != '0 && chosen_position <= POS_W'(MAX_POINTS), "position out of range")
  // A final word taken by the back leaves a result in the output register.
  `PVIS_ASSERT_NEXT(a_result_made, q_pop && q_rd.last, !empty, "result lost")

endmodule
